// ----- rtl/core/cfcc_pkg.sv -----
// Shared codes, widths and types of the x32 CFI flash command controller.
`default_nettype none
package cfcc_pkg;

   // Bus word index width (byte offset bits 16:2)
   localparam int OFF_W  = 15;
   localparam int MODE_W = 3;
   localparam int ERR_W  = 3;

   // Device modes
   localparam logic [MODE_W-1:0] MODE_ARRAY   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_STATUS  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ID      = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ERASE   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_PROGRAM = 3'd4;

   // Bus phases
   localparam logic [1:0] PHASE_CMD    = 2'd0;
   localparam logic [1:0] PHASE_SECOND = 2'd1;
   localparam logic [1:0] PHASE_THIRD  = 2'd2;

   // Error codes
   localparam logic [ERR_W-1:0] ERR_OK       = 3'd0;
   localparam logic [ERR_W-1:0] ERR_UNKNOWN  = 3'd1;
   localparam logic [ERR_W-1:0] ERR_COUNT    = 3'd2;
   localparam logic [ERR_W-1:0] ERR_WINDOW   = 3'd3;
   localparam logic [ERR_W-1:0] ERR_CONFIRM  = 3'd4;
   localparam logic [ERR_W-1:0] ERR_READMODE = 3'd5;

   // Command codes (low half of the bus word)
   localparam logic [15:0] CMD_BLOCK_ERASE  = 16'h0020;
   localparam logic [15:0] CMD_CLEAR_STATUS = 16'h0050;
   localparam logic [15:0] CMD_READ_STATUS  = 16'h0070;
   localparam logic [15:0] CMD_READ_ID      = 16'h0090;
   localparam logic [15:0] CMD_BUF_PROGRAM  = 16'h00e8;
   localparam logic [15:0] CMD_CONFIRM      = 16'h00d0;
   localparam logic [15:0] CMD_READ_ARRAY   = 16'h00ff;

   // Status bits dropped by clear status
   localparam logic [7:0] STATUS_CLEAR_MASK = 8'h3a;
   localparam logic [7:0] STATUS_RESET      = 8'h80;

   // Configuration register indexes
   localparam logic CSR_ERASE_BLOCK = 1'b0;
   localparam logic CSR_FLASH_SIZE  = 1'b1;

   // Reset values of the configuration registers, in words
   localparam int ERASE_WORDS_RESET = 1024;
   localparam int SIZE_WORDS_RESET  = 32768;

   // Kick for the shared array walker
   typedef struct packed {
      logic start;
      logic use_buf;
   } walk_ctl_type;

endpackage
`default_nettype wire

// ----- rtl/core/cfcc_array.sv -----
// Flash array memory, program buffer and the shared address walker for fill and copy.
`default_nettype none
module cfcc_array #(
   parameter int ARRAY_WORDS  = 32768,
   parameter int BUFFER_WORDS = 32,
   parameter int AW           = 15,
   parameter int BW           = 5,
   parameter int CW           = 17
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cfcc_pkg::walk_ctl_type walk_ctl,
   input  wire logic [CW-1:0]         walk_from,
   input  wire logic [CW-1:0]         walk_to,
   output logic                       walk_busy,
   input  wire logic                  buf_wr_en,
   input  wire logic [BW-1:0]         buf_wr_idx,
   input  wire logic [31:0]           buf_wr_data,
   input  wire logic                  rd_en,
   input  wire logic [AW-1:0]         rd_addr,
   output logic [31:0]                rd_data
);
   import cfcc_pkg::*;

   logic [31:0] flash_mem [ARRAY_WORDS];
   logic [31:0] buf_mem [BUFFER_WORDS];
   logic [BUFFER_WORDS-1:0] buf_vld_ff;

   logic          run_ff;
   logic          copy_ff;
   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] end_ff;
   logic [BW-1:0] bidx_ff;
   logic          vld_q_ff;
   logic [CW-1:0] addr_q_ff;
   logic [31:0]   buf_q_ff;
   logic          buf_vld_q_ff;
   logic [31:0]   rd_data_ff;
   logic [31:0]   fill_word;

   // Walker issue stage; reset starts the clearing pass over the whole array
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b1;
         copy_ff  <= 1'b0;
         cnt_ff   <= '0;
         end_ff   <= CW'(ARRAY_WORDS);
         bidx_ff  <= '0;
         vld_q_ff <= 1'b0;
      end else if (walk_ctl.start) begin
         run_ff   <= 1'b1;
         copy_ff  <= walk_ctl.use_buf;
         cnt_ff   <= walk_from;
         end_ff   <= walk_to;
         bidx_ff  <= '0;
         vld_q_ff <= 1'b0;
      end else if (run_ff) begin
         if (cnt_ff < end_ff) begin
            vld_q_ff <= 1'b1;
            cnt_ff   <= cnt_ff + 1'b1;
            bidx_ff  <= bidx_ff + 1'b1;
         end else begin
            run_ff   <= 1'b0;
            vld_q_ff <= 1'b0;
         end
      end else begin
         vld_q_ff <= 1'b0;
      end
   end

   // Carry the issued address into the write stage
   always_ff @(posedge clock) begin
      addr_q_ff <= cnt_ff;
   end

   assign walk_busy = run_ff | vld_q_ff;

   // Program buffer: written by the command path, read by the walker
   always_ff @(posedge clock) begin
      if (buf_wr_en) begin
         buf_mem[buf_wr_idx] <= buf_wr_data;
      end
      buf_q_ff <= buf_mem[bidx_ff];
   end

   // Entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         buf_vld_ff   <= '0;
         buf_vld_q_ff <= 1'b0;
      end else begin
         if (buf_wr_en) begin
            buf_vld_ff[buf_wr_idx] <= 1'b1;
         end
         buf_vld_q_ff <= buf_vld_ff[bidx_ff];
      end
   end

   assign fill_word = copy_ff ? (buf_vld_q_ff ? buf_q_ff : 32'h0) : 32'hffff_ffff;

   // Flash array: one write port for the walker, one registered read port
   always_ff @(posedge clock) begin
      if (vld_q_ff) begin
         flash_mem[addr_q_ff[AW-1:0]] <= fill_word;
      end
      if (rd_en) begin
         rd_data_ff <= flash_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/core/cfi_flash_command_controller_top.sv -----
// Top level of the x32 CFI flash command controller: command sequencer and result register.
`default_nettype none
// x32 CFI flash built from two paired x16 chips. Each request is one 32-bit bus
// read or write; each gives exactly one response with read data and an error code.
// After reset the array is swept to all ones, one word per cycle; requests are
// stalled during that pass while the configuration port stays open. One request
// is in flight at a time. Array reads inside the flash size pass through the
// registered array read port before the result is staged. A block erase, or a
// buffered program confirm whose window fits in the flash size, runs the shared
// address walker, one array word per cycle. A response waiting on a stalled
// output keeps the next request stalled.
module cfi_flash_command_controller_top #(
   parameter int FLASH_BYTES  = 131072,
   parameter int BUFFER_WORDS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_type,
   input  wire logic [16:0] req_byte_offset,
   input  wire logic [31:0] req_write_word,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_read_word,
   output logic [2:0]       rsp_error_code,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [17:0] csr_data
);
   import cfcc_pkg::*;

   localparam int ARRAY_WORDS = FLASH_BYTES / 4;
   localparam int AW   = (ARRAY_WORDS > 1) ? $clog2(ARRAY_WORDS) : 1;
   localparam int BW   = (BUFFER_WORDS > 1) ? $clog2(BUFFER_WORDS) : 1;
   localparam int CNTW = $clog2(BUFFER_WORDS + 1);
   localparam int CW   = (AW + 1 > 17) ? AW + 1 : 17;
   localparam int SIZE_RESET = (SIZE_WORDS_RESET > ARRAY_WORDS) ? ARRAY_WORDS
                                                                : SIZE_WORDS_RESET;

   // Sequencer states
   localparam logic [2:0] S_BOOT = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_EXEC = 3'd2;
   localparam logic [2:0] S_READ = 3'd3;
   localparam logic [2:0] S_WALK = 3'd4;
   localparam logic [2:0] S_FIN  = 3'd5;

   logic [2:0]        state_ff, state_in;

   // Configuration
   logic [13:0]       erase_words_ff;
   logic [CW-1:0]     size_words_ff;
   logic [CW-1:0]     csr_size_words;

   // Device state
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [1:0]        phase_ff, phase_in;
   logic [7:0]        status_ff, status_in;
   logic [CNTW-1:0]   remain_ff, remain_in;
   logic [CNTW-1:0]   count_ff, count_in;
   logic [OFF_W-1:0]  wb_ff, wb_in;

   // Captured item
   logic              it_write_ff;
   logic [OFF_W-1:0]  it_off_ff;
   logic [31:0]       it_word_ff;

   // Staged and output result
   logic [31:0]       res_word_ff, res_word_in;
   logic [ERR_W-1:0]  res_err_ff, res_err_in;
   logic              rsp_valid_ff;
   logic [31:0]       rsp_word_ff;
   logic [ERR_W-1:0]  rsp_err_ff;

   // Array interface
   walk_ctl_type      walk_ctl;
   logic [CW-1:0]     walk_from;
   logic [CW-1:0]     walk_to;
   logic              walk_busy;
   logic              buf_wr_en;
   logic [BW-1:0]     buf_wr_idx;
   logic              rd_en;
   logic [31:0]       rd_data;

   // Decode helpers
   logic [15:0]       cmd;
   logic [CW-1:0]     off_w;
   logic [CW-1:0]     wb_w;
   logic [CW-1:0]     erase_end;
   logic [CW-1:0]     copy_end;
   logic [16:0]       new_count;
   logic [OFF_W-1:0]  win_diff;
   logic              out_free;

   assign cmd       = it_word_ff[15:0];
   assign off_w     = CW'(it_off_ff);
   assign wb_w      = CW'(wb_ff);
   assign erase_end = off_w + CW'(erase_words_ff);
   assign copy_end  = wb_w + CW'(count_ff);
   assign new_count = {1'b0, cmd} + 17'd1;
   assign win_diff  = it_off_ff - wb_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Clip the written flash size to the array
   assign csr_size_words = (CW'(csr_data[17:2]) > CW'(ARRAY_WORDS)) ? CW'(ARRAY_WORDS)
                                                                    : CW'(csr_data[17:2]);

   // Configuration registers are always open
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         erase_words_ff <= 14'(ERASE_WORDS_RESET);
         size_words_ff  <= CW'(SIZE_RESET);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ERASE_BLOCK: erase_words_ff <= csr_data[15:2];
            CSR_FLASH_SIZE:  size_words_ff  <= csr_size_words;
            default:         ;
         endcase
      end
   end

   // Execute the captured item: next device state, result and array kicks
   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      phase_in    = phase_ff;
      status_in   = status_ff;
      remain_in   = remain_ff;
      count_in    = count_ff;
      wb_in       = wb_ff;
      res_word_in = res_word_ff;
      res_err_in  = res_err_ff;
      walk_ctl    = '0;
      walk_from   = off_w;
      walk_to     = (erase_end > size_words_ff) ? size_words_ff : erase_end;
      buf_wr_en   = 1'b0;
      buf_wr_idx  = win_diff[BW-1:0];
      rd_en       = 1'b0;

      unique case (state_ff)
         S_BOOT: begin
            if (!walk_busy) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_word_in = 32'h0;
            res_err_in  = ERR_OK;
            state_in    = S_FIN;
            if (it_write_ff) begin
               if (phase_ff == PHASE_CMD) begin
                  unique case (cmd)
                     CMD_READ_STATUS: mode_in = MODE_STATUS;
                     CMD_READ_ARRAY:  mode_in = MODE_ARRAY;
                     CMD_READ_ID:     mode_in = MODE_ID;
                     CMD_BLOCK_ERASE: begin
                        mode_in  = MODE_ERASE;
                        phase_in = PHASE_SECOND;
                     end
                     CMD_BUF_PROGRAM: begin
                        mode_in  = MODE_PROGRAM;
                        wb_in    = it_off_ff;
                        phase_in = PHASE_SECOND;
                     end
                     CMD_CLEAR_STATUS: begin
                        status_in = status_ff & ~STATUS_CLEAR_MASK;
                        mode_in   = MODE_ARRAY;
                     end
                     default: res_err_in = ERR_UNKNOWN;
                  endcase
               end else if (phase_ff == PHASE_SECOND) begin
                  if (mode_ff == MODE_ERASE) begin
                     // Erase from the addressed word, clipped to the flash size
                     walk_ctl.start = 1'b1;
                     mode_in        = MODE_STATUS;
                     phase_in       = PHASE_CMD;
                     state_in       = S_WALK;
                  end else if (mode_ff == MODE_PROGRAM) begin
                     if (new_count > 17'(BUFFER_WORDS)) begin
                        res_err_in = ERR_COUNT;
                     end else begin
                        remain_in = CNTW'(new_count);
                        count_in  = CNTW'(new_count);
                        phase_in  = PHASE_THIRD;
                     end
                  end
               end else if (phase_ff == PHASE_THIRD && mode_ff == MODE_PROGRAM) begin
                  if (remain_ff == '0) begin
                     if (cmd != CMD_CONFIRM) begin
                        res_err_in = ERR_CONFIRM;
                     end else begin
                        phase_in = PHASE_CMD;
                        mode_in  = MODE_ARRAY;
                        // Copy only when the whole window fits
                        if (copy_end <= size_words_ff) begin
                           walk_ctl.start   = 1'b1;
                           walk_ctl.use_buf = 1'b1;
                           walk_from        = wb_w;
                           walk_to          = copy_end;
                           state_in         = S_WALK;
                        end
                     end
                  end else if (it_off_ff < wb_ff ||
                               CW'(win_diff) >= CW'(count_ff)) begin
                     res_err_in = ERR_WINDOW;
                  end else begin
                     buf_wr_en = 1'b1;
                     remain_in = remain_ff - 1'b1;
                  end
               end
            end else begin
               unique case (mode_ff) inside
                  MODE_ARRAY: begin
                     if (off_w < size_words_ff) begin
                        rd_en    = 1'b1;
                        state_in = S_READ;
                     end else begin
                        res_word_in = 32'hffff_ffff;
                     end
                  end
                  MODE_ID: res_word_in = 32'h0;
                  MODE_STATUS, MODE_PROGRAM: begin
                     res_word_in = {8'h0, status_ff, 8'h0, status_ff};
                  end
                  default: res_err_in = ERR_READMODE;
               endcase
            end
         end
         S_READ: begin
            res_word_in = rd_data;
            state_in    = S_FIN;
         end
         S_WALK: begin
            if (!walk_busy) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_BOOT;
      endcase
   end

   // Sequencer and device state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_BOOT;
         mode_ff   <= MODE_ARRAY;
         phase_ff  <= PHASE_CMD;
         status_ff <= STATUS_RESET;
         remain_ff <= '0;
         count_ff  <= '0;
         wb_ff     <= '0;
      end else begin
         state_ff  <= state_in;
         mode_ff   <= mode_in;
         phase_ff  <= phase_in;
         status_ff <= status_in;
         remain_ff <= remain_in;
         count_ff  <= count_in;
         wb_ff     <= wb_in;
      end
   end

   // Capture the item and stage the result
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         it_write_ff <= req_type;
         it_off_ff   <= req_byte_offset[16:2];
         it_word_ff  <= req_write_word;
      end
      res_word_ff <= res_word_in;
      res_err_ff  <= res_err_in;
   end

   // Output register: load from the finish state, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_FIN && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_FIN && out_free) begin
         rsp_word_ff <= res_word_ff;
         rsp_err_ff  <= res_err_ff;
      end
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_word  = rsp_word_ff;
   assign rsp_error_code = rsp_err_ff;

   cfcc_array #(
      .ARRAY_WORDS  (ARRAY_WORDS),
      .BUFFER_WORDS (BUFFER_WORDS),
      .AW           (AW),
      .BW           (BW),
      .CW           (CW)
   ) u_array (
      .clock       (clock),
      .reset       (reset),
      .walk_ctl    (walk_ctl),
      .walk_from   (walk_from),
      .walk_to     (walk_to),
      .walk_busy   (walk_busy),
      .buf_wr_en   (buf_wr_en),
      .buf_wr_idx  (buf_wr_idx),
      .buf_wr_data (it_word_ff),
      .rd_en       (rd_en),
      .rd_addr     (off_w[AW-1:0]),
      .rd_data     (rd_data)
   );

endmodule
`default_nettype wire
